// ===== design/stable_min_priority_queue_assert.svh =====
// assertion macros for the stable min priority queue
`ifndef STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_MIN_PRIORITY_QUEUE_ASSERT_SVH

// concurrent check on the rising clock, held off while in reset
`define SMPQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the condition
`define SMPQ_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) else $error(msg);

`endif

// ===== design/smpq_pkg.sv =====
// shared types and constants for the stable min priority queue
package smpq_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_PRIO_BITS  = 16;
    localparam int DEF_VALUE_BITS = 16;
    localparam int REQ_BITS       = 2;
    localparam int STATUS_BITS    = 2;

    typedef enum logic [REQ_BITS-1:0] {
        REQ_INSERT = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_QUERY  = 2'd2
    } req_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // per-cycle command broadcast along the cell chain
    typedef struct packed {
        logic ins;
        logic rem;
    } smpq_ctl_t;

endpackage

// ===== design/stable_min_priority_queue.sv =====
// Sorted priority queue built as a row of CAPACITY cells; the head sits in cell 0 and
// equal priorities leave in arrival order. One request is taken per clock cycle: every
// cell compares its priority with the new one and shifts, loads or holds in that same
// cycle, and the result sits in an output register, so a new request is taken whenever
// that register is empty or being drained. Remove on empty and insert on full leave the
// queue unchanged and report it in status. No clearing pass is needed after reset.
module stable_min_priority_queue #(
    parameter int CAPACITY   = smpq_pkg::DEF_CAPACITY,
    parameter int PRIO_BITS  = smpq_pkg::DEF_PRIO_BITS,
    parameter int VALUE_BITS = smpq_pkg::DEF_VALUE_BITS,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int IN_W      = ((VALUE_BITS + PRIO_BITS + 7) / 8) * 8,
    localparam int OUT_RAW   = VALUE_BITS + PRIO_BITS + CNT_W + 1 + smpq_pkg::STATUS_BITS,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [IN_W-1:0]               s_axis_tdata,  // item_value, item_priority
    input  logic [smpq_pkg::REQ_BITS-1:0] s_axis_tuser,  // req_type
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // head_value, head_priority, entry_count, is_empty, status
    output logic [OUT_W-1:0]              m_axis_tdata
);
    import smpq_pkg::*;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    status_t               status_reg;
    status_t               status_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  accept;
    smpq_ctl_t             ctl;
    logic [VALUE_BITS-1:0] in_value;
    logic [PRIO_BITS-1:0]  in_prio;
    logic                  is_empty;

    logic [VALUE_BITS-1:0] cell_value [CAPACITY];
    logic [PRIO_BITS-1:0]  cell_prio  [CAPACITY];
    logic                  cell_take  [CAPACITY];
    logic                  cell_valid [CAPACITY];

    assign in_value      = s_axis_tdata[VALUE_BITS-1:0];
    assign in_prio       = s_axis_tdata[VALUE_BITS+PRIO_BITS-1:VALUE_BITS];
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        ctl         = '0;
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            status_next = ST_OK;
            case (s_axis_tuser)
                REQ_INSERT:
                begin
                    if (count_reg == CNT_W'(CAPACITY))
                        status_next = ST_FULL;
                    else
                    begin
                        ctl.ins    = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                REQ_REMOVE:
                begin
                    if (count_reg == '0)
                        status_next = ST_EMPTY;
                    else
                    begin
                        ctl.rem    = 1'b1;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            status_reg    <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                  l_take;
        logic [VALUE_BITS-1:0] l_value;
        logic [PRIO_BITS-1:0]  l_prio;
        logic [VALUE_BITS-1:0] r_value;
        logic [PRIO_BITS-1:0]  r_prio;

        assign cell_valid[i] = (count_reg > CNT_W'(i));

        if (i == 0)
        begin : g_first
            assign l_take  = 1'b0;
            assign l_value = '0;
            assign l_prio  = '0;
        end
        else
        begin : g_mid
            assign l_take  = cell_take[i-1];
            assign l_value = cell_value[i-1];
            assign l_prio  = cell_prio[i-1];
        end

        // the last slot empties on a remove, its contents no longer count
        if (i == CAPACITY - 1)
        begin : g_last
            assign r_value = '0;
            assign r_prio  = '0;
        end
        else
        begin : g_inner
            assign r_value = cell_value[i+1];
            assign r_prio  = cell_prio[i+1];
        end

        smpq_cell #(
            .VALUE_BITS (VALUE_BITS),
            .PRIO_BITS  (PRIO_BITS)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .valid       (cell_valid[i]),
            .new_value   (in_value),
            .new_prio    (in_prio),
            .left_take   (l_take),
            .left_value  (l_value),
            .left_prio   (l_prio),
            .right_value (r_value),
            .right_prio  (r_prio),
            .take        (cell_take[i]),
            .value       (cell_value[i]),
            .prio        (cell_prio[i])
        );
    end

    // the queue only moves on an accepted request, so the head holds while stalled
    assign is_empty      = (count_reg == '0);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'({status_reg,
                                   is_empty,
                                   count_reg,
                                   is_empty ? {PRIO_BITS{1'b0}}  : cell_prio[0],
                                   is_empty ? {VALUE_BITS{1'b0}} : cell_value[0]});

endmodule

// ===== design/smpq_cell.sv =====
// one slot of the sorted chain: holds an entry and shifts with its neighbours
module smpq_cell #(
    parameter int VALUE_BITS = 16,
    parameter int PRIO_BITS  = 16
) (
    input  logic                  clk,
    input  smpq_pkg::smpq_ctl_t   ctl,
    input  logic                  valid,
    input  logic [VALUE_BITS-1:0] new_value,
    input  logic [PRIO_BITS-1:0]  new_prio,
    input  logic                  left_take,
    input  logic [VALUE_BITS-1:0] left_value,
    input  logic [PRIO_BITS-1:0]  left_prio,
    input  logic [VALUE_BITS-1:0] right_value,
    input  logic [PRIO_BITS-1:0]  right_prio,
    output logic                  take,
    output logic [VALUE_BITS-1:0] value,
    output logic [PRIO_BITS-1:0]  prio
);
    import smpq_pkg::*;

    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;
    logic [PRIO_BITS-1:0]  prio_reg;
    logic [PRIO_BITS-1:0]  prio_next;

    // equal priorities stay ahead of the new entry
    assign take  = !valid || (prio_reg > new_prio);
    assign value = value_reg;
    assign prio  = prio_reg;

    always_comb
    begin
        value_next = value_reg;
        prio_next  = prio_reg;
        if (ctl.ins && take)
        begin
            if (left_take)
            begin
                value_next = left_value;
                prio_next  = left_prio;
            end
            else
            begin
                value_next = new_value;
                prio_next  = new_prio;
            end
        end
        else if (ctl.rem)
        begin
            value_next = right_value;
            prio_next  = right_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        prio_reg  <= prio_next;
    end

endmodule

// ===== design/smpq_checker.sv =====
// port-level checks for the stable min priority queue, bound to the top level
`include "stable_min_priority_queue_assert.svh"

module smpq_checker #(
    parameter int CAPACITY   = smpq_pkg::DEF_CAPACITY,
    parameter int PRIO_BITS  = smpq_pkg::DEF_PRIO_BITS,
    parameter int VALUE_BITS = smpq_pkg::DEF_VALUE_BITS,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int OUT_RAW   = VALUE_BITS + PRIO_BITS + CNT_W + 1 + smpq_pkg::STATUS_BITS,
    localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata
);
    import smpq_pkg::*;

    localparam int CNT_LO = VALUE_BITS + PRIO_BITS;
    localparam int EMP_B  = CNT_LO + CNT_W;
    localparam int ST_LO  = EMP_B + 1;

    logic [CNT_W-1:0]       cnt;
    logic                   emp;
    logic [STATUS_BITS-1:0] st;

    assign cnt = m_axis_tdata[EMP_B-1:CNT_LO];
    assign emp = m_axis_tdata[EMP_B];
    assign st  = m_axis_tdata[ST_LO+STATUS_BITS-1:ST_LO];

    `SMPQ_ASSERT(a_empty_flag, m_axis_tvalid |-> (emp == (cnt == '0)), "empty flag disagrees with count")
    `SMPQ_ASSERT(a_remove_empty, (m_axis_tvalid && st == ST_EMPTY) |-> emp, "remove refused on a non-empty queue")
    `SMPQ_ASSERT(a_insert_full, (m_axis_tvalid && st == ST_FULL) |-> (cnt == CNT_W'(CAPACITY)), "insert refused below capacity")
    `SMPQ_ASSERT_NEXT(a_result_follows, s_axis_tvalid && s_axis_tready, m_axis_tvalid, "request gave no result")
    `SMPQ_ASSERT_NEXT(a_hold_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")

endmodule

bind stable_min_priority_queue smpq_checker #(
    .CAPACITY   (CAPACITY),
    .PRIO_BITS  (PRIO_BITS),
    .VALUE_BITS (VALUE_BITS)
) u_smpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
